// File: src/open_address_hash_set_top_defines.svh
// ----------------------------------------------------------------------------
// Hash set assertion macros
// Shared helpers for concurrent checks, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_SET_TOP_DEFINES_SVH
`define OPEN_ADDRESS_HASH_SET_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define OHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent
`define OHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ohs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set package
// Sizes, slot and request codes, controller/datapath structs and key hashing.
// ----------------------------------------------------------------------------
package ohs_pkg;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned KEY_BYTES   = 8;
  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned KEY_TOTAL_W = 9;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_DELETED  = 2'd2
  } mark_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } state_e;

  typedef struct packed {
    mark_e            mark;
    logic [KEY_W-1:0] key;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] home;
  } hash_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic advance;
    logic take_target;
    logic wr_ins;
    logic wr_del;
    logic set_ok;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    mark_e            mark;
    logic             key_hit;
    logic             last_probe;
    logic             have_target;
    logic             rsp_free;
  } dp_status_t;

  // Cut the key at its first zero byte; Horner hash kept modulo CAPACITY
  function automatic hash_t hash_key(input logic [KEY_W-1:0] raw);
    hash_t            res;
    logic             live;
    logic [7:0]       byt;
    logic [IDX_W-1:0] h;
    res  = '0;
    live = 1'b1;
    h    = '0;
    for (int b = KEY_BYTES - 1; b >= 0; b--) begin
      byt = raw[b*8 +: 8];
      if (byt == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        res.key[b*8 +: 8] = byt;
        h = IDX_W'({h, 3'b000} - {3'b000, h} + (IDX_W + 3)'(byt));
      end
    end
    res.home = h;
    return res;
  endfunction

endpackage

// File: src/ohs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request item: type and key.
// ----------------------------------------------------------------------------
interface ohs_req_if;
  logic                        valid;
  logic                        ready;
  logic [ohs_pkg::REQ_W-1:0]   req_type;
  logic [ohs_pkg::KEY_W-1:0]   key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

// File: src/ohs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result item: success flag and key count.
// ----------------------------------------------------------------------------
interface ohs_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              success;
  logic [ohs_pkg::KEY_TOTAL_W-1:0]   key_total;

  modport source (output valid, output success, output key_total, input ready);
  modport sink   (input valid, input success, input key_total, output ready);
endinterface

// File: src/ohs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write a cycle, read data registered.
// ----------------------------------------------------------------------------
module ohs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ohs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set controller
// Sequences accept, probe read, slot check, table update and result hand-off.
// ----------------------------------------------------------------------------
`include "open_address_hash_set_top_defines.svh"

module ohs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  ohs_pkg::dp_status_t status_i,
  output ohs_pkg::ctrl_cmd_t  cmd_o
);
  import ohs_pkg::*;

  state_e state_q, state_d;
  logic   probe_stop;
  logic   grab_tomb;

  // A probe ends at an empty slot, on the key itself, or on the last slot
  assign probe_stop = (status_i.mark == MARK_EMPTY) || status_i.key_hit ||
                      status_i.last_probe;
  assign grab_tomb  = (status_i.mark == MARK_DELETED) && !status_i.have_target;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        unique case (status_i.req)
          REQ_LOOKUP, REQ_INSERT, REQ_DELETE: begin
            state_d = probe_stop ? ST_RESP : ST_READ;
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end
      ST_RESP: begin
        if (status_i.rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      ST_CHECK: begin
        unique case (status_i.req)
          REQ_LOOKUP: begin
            cmd_o.set_ok  = status_i.key_hit;
            cmd_o.advance = !probe_stop;
          end
          REQ_DELETE: begin
            cmd_o.wr_del  = status_i.key_hit;
            cmd_o.advance = !probe_stop;
          end
          REQ_INSERT: begin
            cmd_o.wr_ins      = !status_i.key_hit &&
                                ((status_i.mark == MARK_EMPTY) ||
                                 (status_i.last_probe &&
                                  (status_i.have_target || grab_tomb)));
            cmd_o.take_target = grab_tomb && !probe_stop;
            cmd_o.advance     = !probe_stop;
          end
          default: begin
            cmd_o = '0;
          end
        endcase
      end
      ST_RESP: begin
        cmd_o.emit = status_i.rsp_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `OHS_ASSERT(a_check_follows_read, (state_q == ST_CHECK) |-> ($past(state_q) == ST_READ), "slot check without a preceding read")
  `OHS_ASSERT_NEXT(a_accept_starts_probe, req_valid_i && req_ready_o, state_q == ST_READ, "accepted item did not start a probe")

endmodule

// File: src/ohs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set datapath
// Key hashing, probe index, slot table with valid bits, count and result.
// ----------------------------------------------------------------------------
`include "open_address_hash_set_top_defines.svh"

module ohs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ohs_pkg::ctrl_cmd_t                  cmd_i,
  output ohs_pkg::dp_status_t                 status_o,
  input  logic [ohs_pkg::REQ_W-1:0]           req_type_i,
  input  logic [ohs_pkg::KEY_W-1:0]           key_i,
  input  logic                                rsp_ready_i,
  output logic                                rsp_valid_o,
  output logic                                rsp_success_o,
  output logic [ohs_pkg::KEY_TOTAL_W-1:0]     rsp_key_total_o
);
  import ohs_pkg::*;

  hash_t               hash;
  logic [REQ_W-1:0]    req_q;
  logic [KEY_W-1:0]    key_q;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    probe_q;
  logic [IDX_W-1:0]    target_q;
  logic                have_target_q;
  logic                ok_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CAPACITY-1:0] valid_q;
  logic                valid_rd_q;
  logic                rsp_valid_q;
  logic                success_q;
  logic [KEY_TOTAL_W-1:0] total_q;

  logic                ram_en, ram_we;
  logic [IDX_W-1:0]    ram_addr, ins_addr;
  slot_t               wr_slot, rd_slot;
  logic [SLOT_W-1:0]   ram_rdata;
  mark_e               seen_mark;
  logic                rsp_free;

  assign hash     = hash_key(key_i);
  assign idx_d    = idx_q + probe_q + IDX_W'(1);
  assign ins_addr = have_target_q ? target_q : idx_q;

  assign ram_we   = cmd_i.wr_ins || cmd_i.wr_del;
  assign ram_en   = cmd_i.rd || ram_we;
  assign ram_addr = cmd_i.wr_ins ? ins_addr : idx_q;
  assign wr_slot  = '{mark: (cmd_i.wr_ins ? MARK_OCCUPIED : MARK_DELETED), key: key_q};
  assign rd_slot  = ram_rdata;

  ohs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wr_slot),
    .rdata_o (ram_rdata)
  );

  // A slot never written reads as empty
  assign seen_mark = valid_rd_q ? rd_slot.mark : MARK_EMPTY;
  assign rsp_free  = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    status_o             = '0;
    status_o.req         = req_q;
    status_o.mark        = seen_mark;
    status_o.key_hit     = (seen_mark == MARK_OCCUPIED) && (rd_slot.key == key_q);
    status_o.last_probe  = (probe_q == IDX_W'(CAPACITY - 1));
    status_o.have_target = have_target_q;
    status_o.rsp_free    = rsp_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_target_q <= 1'b0;
      ok_q          <= 1'b0;
      cnt_q         <= '0;
      valid_q       <= '0;
      valid_rd_q    <= 1'b0;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        have_target_q <= 1'b0;
        ok_q          <= 1'b0;
      end else begin
        if (cmd_i.take_target) begin
          have_target_q <= 1'b1;
        end
        if (cmd_i.set_ok || ram_we) begin
          ok_q <= 1'b1;
        end
      end
      if (cmd_i.wr_ins) begin
        cnt_q              <= cnt_q + CNT_W'(1);
        valid_q[ins_addr]  <= 1'b1;
      end else if (cmd_i.wr_del) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.rd) begin
        valid_rd_q <= valid_q[idx_q];
      end
      if (cmd_i.emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      key_q   <= hash.key;
      idx_q   <= hash.home;
      probe_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q   <= idx_d;
      probe_q <= probe_q + IDX_W'(1);
    end
    if (cmd_i.take_target) begin
      target_q <= idx_q;
    end
    if (cmd_i.emit) begin
      success_q <= ok_q;
      total_q   <= KEY_TOTAL_W'(cnt_q);
    end
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign rsp_success_o   = success_q;
  assign rsp_key_total_o = total_q;

  `OHS_ASSERT(a_insert_has_room, cmd_i.wr_ins |-> (cnt_q < CAPACITY), "insert into a full table")
  `OHS_ASSERT(a_delete_has_key, cmd_i.wr_del |-> (cnt_q != '0), "delete with no occupied slot")
  `OHS_ASSERT_NEXT(a_insert_counts, cmd_i.wr_ins, cnt_q == $past(cnt_q) + 1'b1, "insert did not raise the count")

endmodule

// File: src/open_address_hash_set_top.sv
`timescale 1ns / 1ps
// A request is accepted in ST_IDLE and probes P slots (1..CAPACITY); the result is then
// registered in ST_RESP once the output register is free. One request is handled at a
// time; each probe is a slot RAM read followed by a check of the registered slot.
// The next request is accepted while a result still waits in the output register.
// Reset: asynchronous, active low; clears all slot valid bits and the count at once,
// so the table is empty with no clearing pass.
// ----------------------------------------------------------------------------
// Open addressing hash set
// Lookup, insert and delete of up to eight-byte keys with triangular probing.
// ----------------------------------------------------------------------------
module open_address_hash_set_top (
  input logic      clk_i,
  input logic      rst_ni,
  ohs_req_if.sink   req_i,
  ohs_rsp_if.source rsp_o
);
  import ohs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       req_ready;
  logic       rsp_valid;
  logic       rsp_success;
  logic [KEY_TOTAL_W-1:0] rsp_key_total;

  ohs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ohs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (req_i.req_type),
    .key_i           (req_i.key),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_valid),
    .rsp_success_o   (rsp_success),
    .rsp_key_total_o (rsp_key_total)
  );

  assign req_i.ready     = req_ready;
  assign rsp_o.valid     = rsp_valid;
  assign rsp_o.success   = rsp_success;
  assign rsp_o.key_total = rsp_key_total;

endmodule
